/* rtl/in_order_version_release_queue_unit_macros.svh */
// Assertion macros for the in-order version release queue.
`ifndef IN_ORDER_VERSION_RELEASE_QUEUE_UNIT_MACROS_SVH
`define IN_ORDER_VERSION_RELEASE_QUEUE_UNIT_MACROS_SVH

// Check that cond implies prop on every clock outside reset.
`define OVRQ_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("ovrq implication check failed");

// Check that bad never holds outside reset.
`define OVRQ_ASSERT_NEVER(label, clk, rst_n, bad) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(bad)) \
    else $error("ovrq forbidden condition seen");

`endif

/* rtl/ovrq_pkg.sv */
// Shared types and codes of the in-order version release queue.
package ovrq_pkg;
  localparam int VerW   = 64;
  localparam int PayW   = 32;
  localparam int CntOutW = 7;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SET = 2'd1;
  localparam logic [1:0] CMD_GET = 2'd2;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_SET       = 3'd1;
  localparam logic [2:0] ST_DELIVERED = 3'd2;
  localparam logic [2:0] ST_NONE      = 3'd3;
  localparam logic [2:0] ST_WAIT      = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  typedef struct packed {
    logic [VerW-1:0] ver;
    logic [PayW-1:0] pay;
  } entry_t;

  function automatic logic [VerW-1:0] sat_inc(input logic [VerW-1:0] v);
    sat_inc = (v == {VerW{1'b1}}) ? v : v + VerW'(1);
  endfunction
endpackage

/* rtl/in_order_version_release_queue_unit.sv */
// In-order version release queue: entry store, min scan and expected-version counter.
// Add, set and unknown commands give their result in the cycle after the request is accepted.
// A get scans the held entries one per cycle through a single compare unit, then decides in
// S_DECIDE and, when it releases an entry, fills its hole in S_MOVE; an empty store skips the scan.
// One request in flight; the next is taken the cycle after the result is accepted.
// Reset: synchronous active-low; clears count to 0, counter to 1 and out_valid; store kept.
module in_order_version_release_queue_unit
  import ovrq_pkg::*;
#(
  parameter int HEAP_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_command,
  input  logic [VerW-1:0]  in_version,
  input  logic [PayW-1:0]  in_payload,
  input  logic             in_wait_flag,
  input  logic [VerW-1:0]  in_required_version,
  input  logic [VerW-1:0]  in_current_version,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_status,
  output logic [VerW-1:0]  out_version,
  output logic [PayW-1:0]  out_payload,
  output logic [CntOutW-1:0] out_entry_count,
  output logic [VerW-1:0]  out_expected_next
);
  `include "in_order_version_release_queue_unit_macros.svh"

  localparam int IW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW = $clog2(HEAP_DEPTH + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_MOVE   = 2'd3;

  // Entry store: one write and one registered read port.
  entry_t mem [HEAP_DEPTH];
  entry_t rd_data_r;
  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  entry_t        wr_data;

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  logic [1:0]      state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [VerW-1:0] exp_r, exp_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [IW-1:0]   best_idx_r, best_idx_nxt;
  entry_t          best_r, best_nxt;
  logic            wait_r, wait_nxt;
  logic [VerW-1:0] req_r, req_nxt;

  logic            ov_r, ov_nxt;
  logic [2:0]      st_r, st_nxt;
  logic [VerW-1:0] over_r, over_nxt;
  logic [PayW-1:0] opay_r, opay_nxt;

  logic            accept;
  logic [VerW-1:0] exp_cur;
  logic            take;
  logic            ready_hit;

  assign in_ready = (state_r == S_IDLE) && !ov_r;
  assign accept   = in_valid && in_ready;

  // Raise the counter past the caller's applied version when it lags.
  assign exp_cur = (exp_r <= in_current_version) ? sat_inc(in_current_version) : exp_r;

  // Shared compare unit: keep the smaller (version, payload) key.
  assign take = (idx_r == '0) || (rd_data_r < best_r);
  assign ready_hit = best_r.ver <= exp_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    exp_nxt      = exp_r;
    idx_nxt      = idx_r;
    best_idx_nxt = best_idx_r;
    best_nxt     = best_r;
    wait_nxt     = wait_r;
    req_nxt      = req_r;
    ov_nxt       = ov_r && !out_ready;
    st_nxt       = st_r;
    over_nxt     = over_r;
    opay_nxt     = opay_r;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = cnt_r[IW-1:0];
    wr_data      = '{ver: in_version, pay: in_payload};

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          over_nxt = '0;
          opay_nxt = '0;
          case (in_command)
            CMD_ADD: begin
              ov_nxt = 1'b1;
              if (cnt_r == CW'(HEAP_DEPTH)) begin
                st_nxt = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                cnt_nxt = cnt_r + CW'(1);
                st_nxt  = ST_ADDED;
              end
            end
            CMD_SET: begin
              ov_nxt = 1'b1;
              st_nxt = ST_SET;
              if (exp_r < in_version) exp_nxt = in_version;
            end
            CMD_GET: begin
              exp_nxt  = exp_cur;
              wait_nxt = in_wait_flag;
              req_nxt  = in_required_version;
              if (cnt_r == '0) begin
                // Empty store: nothing to release.
                ov_nxt = 1'b1;
                st_nxt = (in_wait_flag && in_required_version >= exp_cur) ? ST_WAIT : ST_NONE;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                idx_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              ov_nxt = 1'b1;
              st_nxt = ST_NONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (take) begin
          best_nxt     = rd_data_r;
          best_idx_nxt = idx_r;
        end
        if (CW'(idx_r) + CW'(1) < cnt_r) begin
          rd_en   = 1'b1;
          rd_addr = idx_r + IW'(1);
          idx_nxt = idx_r + IW'(1);
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (ready_hit) begin
          // Fetch the last entry to fill the hole left by the released one.
          cnt_nxt   = cnt_r - CW'(1);
          rd_en     = 1'b1;
          rd_addr   = cnt_nxt[IW-1:0];
          st_nxt    = ST_DELIVERED;
          over_nxt  = best_r.ver;
          opay_nxt  = best_r.pay;
          if (best_r.ver == exp_r) exp_nxt = sat_inc(exp_r);
          state_nxt = S_MOVE;
        end else begin
          st_nxt    = (wait_r && req_r >= exp_r) ? ST_WAIT : ST_NONE;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_MOVE: begin
        wr_en     = 1'b1;
        wr_addr   = best_idx_r;
        wr_data   = rd_data_r;
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      exp_r   <= VerW'(1);
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      exp_r   <= exp_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    wait_r     <= wait_nxt;
    req_r      <= req_nxt;
    st_r       <= st_nxt;
    over_r     <= over_nxt;
    opay_r     <= opay_nxt;
  end

  assign out_valid         = ov_r;
  assign out_status        = st_r;
  assign out_version       = over_r;
  assign out_payload       = opay_r;
  assign out_entry_count   = CntOutW'(cnt_r);
  assign out_expected_next = exp_r;

  `OVRQ_ASSERT_NEVER(a_cnt_bound, clk, rst_n, cnt_r > CW'(HEAP_DEPTH))
  `OVRQ_ASSERT_IMPLIES(a_exp_mono, clk, rst_n, $past(rst_n), exp_r >= $past(exp_r))
  `OVRQ_ASSERT_IMPLIES(a_deliv_ok, clk, rst_n, ov_r && st_r == ST_DELIVERED, over_r <= exp_r)
  `OVRQ_ASSERT_IMPLIES(a_busy_no_out, clk, rst_n, state_r != S_IDLE, !ov_r)
endmodule
